>>> rtl/tpwm_pkg.sv
// shared constants and types for the tick pwm block with shadow update
`default_nettype none

package tpwm_pkg;

   localparam int COUNT_WIDTH_DEFAULT    = 24;
   localparam int DUTY_FRAC_BITS_DEFAULT = 16;

   // period loaded at reset, duty at reset is one half
   localparam int RESET_PERIOD = 1000;

   localparam logic KIND_TICK   = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   typedef struct packed {
      logic kind;
      logic defer_update;
   } req_ctl_type;

endpackage

`default_nettype wire

>>> rtl/tpwm_channels.sv
// valid/ready channel interfaces for request and response
`default_nettype none

interface tpwm_req_if #(
   parameter int COUNT_WIDTH    = tpwm_pkg::COUNT_WIDTH_DEFAULT,
   parameter int DUTY_FRAC_BITS = tpwm_pkg::DUTY_FRAC_BITS_DEFAULT
) ();
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [COUNT_WIDTH-1:0]    new_period;
   logic [DUTY_FRAC_BITS:0]   new_duty;
   logic                      defer_update;

   modport source (output valid, kind, new_period, new_duty, defer_update, input ready);
   modport sink   (input valid, kind, new_period, new_duty, defer_update, output ready);
endinterface

interface tpwm_rsp_if ();
   logic valid;
   logic ready;
   logic pin_level;
   logic phase_switched;

   modport source (output valid, pin_level, phase_switched, input ready);
   modport sink   (input valid, pin_level, phase_switched, output ready);
endinterface

`default_nettype wire

>>> rtl/tpwm_in_reg.sv
// input register stage for tick and update requests
`default_nettype none

module tpwm_in_reg #(
   parameter int COUNT_WIDTH    = tpwm_pkg::COUNT_WIDTH_DEFAULT,
   parameter int DUTY_FRAC_BITS = tpwm_pkg::DUTY_FRAC_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_kind,
   input  wire logic [COUNT_WIDTH-1:0]  req_new_period,
   input  wire logic [DUTY_FRAC_BITS:0] req_new_duty,
   input  wire logic                    req_defer_update,
   output logic                         stage_valid,
   output tpwm_pkg::req_ctl_type        stage_ctl,
   output logic [COUNT_WIDTH-1:0]       stage_period,
   output logic [DUTY_FRAC_BITS:0]      stage_duty,
   input  wire logic                    stage_take
);

   logic                     valid_ff, valid_in;
   tpwm_pkg::req_ctl_type    ctl_ff;
   logic [COUNT_WIDTH-1:0]   period_ff;
   logic [DUTY_FRAC_BITS:0]  duty_ff;
   logic                     load;

   assign req_ready = !valid_ff || stage_take;
   assign load      = req_valid && req_ready;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctl_ff.kind         <= req_kind;
         ctl_ff.defer_update <= req_defer_update;
         period_ff           <= req_new_period;
         duty_ff             <= req_new_duty;
      end
   end

   assign stage_valid  = valid_ff;
   assign stage_ctl    = ctl_ff;
   assign stage_period = period_ff;
   assign stage_duty   = duty_ff;

endmodule

`default_nettype wire

>>> rtl/tpwm_core.sv
// pwm phase state, on-time multiply and response register
`default_nettype none

module tpwm_core #(
   parameter int COUNT_WIDTH    = tpwm_pkg::COUNT_WIDTH_DEFAULT,
   parameter int DUTY_FRAC_BITS = tpwm_pkg::DUTY_FRAC_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    stage_valid,
   input  wire tpwm_pkg::req_ctl_type   stage_ctl,
   input  wire logic [COUNT_WIDTH-1:0]  stage_period,
   input  wire logic [DUTY_FRAC_BITS:0] stage_duty,
   output logic                         stage_take,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_pin_level,
   output logic                         rsp_phase_switched
);

   localparam int PROD_WIDTH = COUNT_WIDTH + DUTY_FRAC_BITS + 1;
   localparam logic [COUNT_WIDTH-1:0] RESET_PERIOD = COUNT_WIDTH'(tpwm_pkg::RESET_PERIOD);
   localparam logic [COUNT_WIDTH-1:0] RESET_ON     = RESET_PERIOD >> 1;
   localparam logic [DUTY_FRAC_BITS:0] DUTY_ONE    = (DUTY_FRAC_BITS+1)'(1) << DUTY_FRAC_BITS;

   logic                    active_ff, active_in;
   logic                    defer_ff, defer_in;
   logic [COUNT_WIDTH-1:0]  period_now_ff, period_now_in;
   logic [COUNT_WIDTH-1:0]  on_now_ff, on_now_in;
   logic [COUNT_WIDTH-1:0]  pend_period_ff, pend_period_in;
   logic [COUNT_WIDTH-1:0]  pend_on_ff, pend_on_in;
   logic [COUNT_WIDTH-1:0]  elapsed_ff, elapsed_in;
   logic [COUNT_WIDTH-1:0]  delay_ff, delay_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    pin_ff, pin_in;
   logic                    switched_ff, switched_in;

   logic [DUTY_FRAC_BITS:0] duty_sat;
   logic [PROD_WIDTH-1:0]   prod;
   logic [COUNT_WIDTH-1:0]  on_new;
   logic [COUNT_WIDTH-1:0]  elapsed_inc;
   logic                    hit;

   assign stage_take = stage_valid && (!rsp_valid_ff || rsp_ready);

   // saturate duty to one, on-time = floor(period * duty)
   assign duty_sat = (stage_duty > DUTY_ONE) ? DUTY_ONE : stage_duty;
   assign prod     = PROD_WIDTH'(stage_period) * PROD_WIDTH'(duty_sat);
   assign on_new   = prod[DUTY_FRAC_BITS +: COUNT_WIDTH];

   assign elapsed_inc = elapsed_ff + COUNT_WIDTH'(1);
   assign hit         = elapsed_inc >= delay_ff;

   always_comb begin
      active_in      = active_ff;
      defer_in       = defer_ff;
      period_now_in  = period_now_ff;
      on_now_in      = on_now_ff;
      pend_period_in = pend_period_ff;
      pend_on_in     = pend_on_ff;
      elapsed_in     = elapsed_ff;
      delay_in       = delay_ff;
      switched_in    = switched_ff;
      pin_in         = pin_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      if (stage_take) begin
         rsp_valid_in = 1'b1;
         switched_in  = 1'b0;
         if (stage_ctl.kind == tpwm_pkg::KIND_UPDATE) begin
            pend_period_in = stage_period;
            pend_on_in     = on_new;
            defer_in       = stage_ctl.defer_update;
            if (!stage_ctl.defer_update) begin
               period_now_in = stage_period;
               on_now_in     = on_new;
            end
         end else begin
            elapsed_in = elapsed_inc;
            if (hit) begin
               elapsed_in  = elapsed_inc - delay_ff;
               switched_in = 1'b1;
               if (active_ff) begin
                  active_in = 1'b0;
                  delay_in  = period_now_ff - on_now_ff;
               end else begin
                  active_in = 1'b1;
                  if (defer_ff) begin
                     period_now_in = pend_period_ff;
                     on_now_in     = pend_on_ff;
                     delay_in      = pend_on_ff;
                  end else begin
                     delay_in = on_now_ff;
                  end
               end
            end
         end
         pin_in = active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b1;
         defer_ff       <= 1'b0;
         period_now_ff  <= RESET_PERIOD;
         on_now_ff      <= RESET_ON;
         pend_period_ff <= RESET_PERIOD;
         pend_on_ff     <= RESET_ON;
         elapsed_ff     <= '0;
         delay_ff       <= RESET_ON;
         rsp_valid_ff   <= 1'b0;
      end else begin
         active_ff      <= active_in;
         defer_ff       <= defer_in;
         period_now_ff  <= period_now_in;
         on_now_ff      <= on_now_in;
         pend_period_ff <= pend_period_in;
         pend_on_ff     <= pend_on_in;
         elapsed_ff     <= elapsed_in;
         delay_ff       <= delay_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pin_ff      <= pin_in;
      switched_ff <= switched_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pin_level      = pin_ff;
   assign rsp_phase_switched = switched_ff;

   a_on_le_period: assert property (@(posedge clock) disable iff (reset)
      (on_now_ff <= period_now_ff) && (pend_on_ff <= pend_period_ff))
      else $error("on-time exceeds period");

   a_update_no_switch: assert property (@(posedge clock) disable iff (reset)
      stage_take && (stage_ctl.kind == tpwm_pkg::KIND_UPDATE) |=> !switched_ff)
      else $error("update transfer reported a phase switch");

   a_pin_tracks_phase: assert property (@(posedge clock) disable iff (reset)
      stage_take |=> (pin_ff == active_ff))
      else $error("pin level differs from phase");

   a_switch_flips: assert property (@(posedge clock) disable iff (reset)
      stage_take |=> (switched_ff == (active_ff != $past(active_ff))))
      else $error("phase switch flag and phase change disagree");

endmodule

`default_nettype wire

>>> rtl/tick_pwm_with_shadow_update.sv
// top level of the tick pwm generator with shadow period and duty update
`default_nettype none

// Each request is either a tick, which advances the phase counter by one and may flip
// the pwm pin, or an update of period and duty (Q1.DUTY_FRAC_BITS, saturated to 1.0).
// An immediate update takes effect at the next phase switch; a deferred update is
// reapplied at every start of the active phase until an immediate update clears it.
// Every request yields one response with the pin level and a phase switch flag.
// One request per clock is accepted while the response register is free or being taken;
// each request passes through the input register and then through the counter compare
// or the on-time multiply into the response register.
module tick_pwm_with_shadow_update #(
   parameter int COUNT_WIDTH    = tpwm_pkg::COUNT_WIDTH_DEFAULT,
   parameter int DUTY_FRAC_BITS = tpwm_pkg::DUTY_FRAC_BITS_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   tpwm_req_if.sink    req_ch,
   tpwm_rsp_if.source  rsp_ch
);

   logic                     stage_valid;
   tpwm_pkg::req_ctl_type    stage_ctl;
   logic [COUNT_WIDTH-1:0]   stage_period;
   logic [DUTY_FRAC_BITS:0]  stage_duty;
   logic                     stage_take;

   tpwm_in_reg #(
      .COUNT_WIDTH    (COUNT_WIDTH),
      .DUTY_FRAC_BITS (DUTY_FRAC_BITS)
   ) u_in_reg (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_kind         (req_ch.kind),
      .req_new_period   (req_ch.new_period),
      .req_new_duty     (req_ch.new_duty),
      .req_defer_update (req_ch.defer_update),
      .stage_valid      (stage_valid),
      .stage_ctl        (stage_ctl),
      .stage_period     (stage_period),
      .stage_duty       (stage_duty),
      .stage_take       (stage_take)
   );

   tpwm_core #(
      .COUNT_WIDTH    (COUNT_WIDTH),
      .DUTY_FRAC_BITS (DUTY_FRAC_BITS)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .stage_valid        (stage_valid),
      .stage_ctl          (stage_ctl),
      .stage_period       (stage_period),
      .stage_duty         (stage_duty),
      .stage_take         (stage_take),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_pin_level      (rsp_ch.pin_level),
      .rsp_phase_switched (rsp_ch.phase_switched)
   );

endmodule

`default_nettype wire

>>> dv/tick_pwm_with_shadow_update_test.sv
// self-checking testbench for the tick pwm generator with shadow period and duty update
`default_nettype none

module tick_pwm_with_shadow_update_test;

   localparam int CW          = tpwm_pkg::COUNT_WIDTH_DEFAULT;
   localparam int DF          = tpwm_pkg::DUTY_FRAC_BITS_DEFAULT;
   localparam int DW          = DF + 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;
   localparam logic [DF:0] DUTY_ONE = {1'b1, {DF{1'b0}}};

   typedef struct packed {
      logic pin_level;
      logic phase_switched;
   } pwm_level_type;

   logic clock;
   logic reset;

   tpwm_req_if req_ch ();
   tpwm_rsp_if rsp_ch ();

   tick_pwm_with_shadow_update dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // pwm predictor state
   logic          pwm_phase_active;
   logic [CW-1:0] cur_period;
   logic [DF:0]   cur_duty;
   logic [CW-1:0] on_len;
   logic [CW-1:0] off_len;
   logic [CW-1:0] shadow_period;
   logic [DF:0]   shadow_duty;
   logic          shadow_sticky;
   logic [CW-1:0] tick_count;
   logic [CW-1:0] phase_len;

   pwm_level_type pending_levels[$];

   int          burst_left    = 0;
   bit          sender_steady = 0;
   logic [15:0] sink_pattern  = 16'hFFFF;
   int          sink_age      = 0;
   int          cycle_count   = 0;
   int          bad_results   = 0;
   int          checked       = 0;
   int          ticks_sent    = 0;
   int          updates_sent  = 0;
   int          flips_seen    = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void load_shadow();
      logic [CW+DF:0] product;
      cur_period = shadow_period;
      cur_duty   = shadow_duty;
      product    = cur_period * cur_duty;
      on_len     = product[CW+DF-1:DF];
      off_len    = cur_period - on_len;
   endfunction

   function automatic pwm_level_type advance_pwm(input logic kind, input logic [CW-1:0] period,
                                                 input logic [DF:0] duty, input logic defer);
      pwm_level_type res;
      res.phase_switched = 1'b0;
      if (kind == tpwm_pkg::KIND_UPDATE) begin
         shadow_period = period;
         shadow_duty   = (duty > DUTY_ONE) ? DUTY_ONE : duty;
         shadow_sticky = defer;
         if (!defer) load_shadow();
      end else begin
         tick_count = tick_count + 1'b1;
         if (tick_count >= phase_len) begin
            tick_count = tick_count - phase_len;
            res.phase_switched = 1'b1;
            if (pwm_phase_active) begin
               pwm_phase_active = 1'b0;
               phase_len = off_len;
            end else begin
               pwm_phase_active = 1'b1;
               if (shadow_sticky) load_shadow();
               phase_len = on_len;
            end
         end
      end
      res.pin_level = pwm_phase_active;
      return res;
   endfunction

   function automatic logic [DF:0] random_duty();
      case ($urandom_range(0, 3))
         0: return DW'($urandom_range(0, int'(DUTY_ONE)));
         1: return DW'($urandom);
         2: return $urandom_range(0, 1) ? DUTY_ONE - DW'($urandom_range(0, 1))
                                        : DW'($urandom_range(0, 1));
         default: return DUTY_ONE + DW'($urandom_range(1, int'(DUTY_ONE) - 1));
      endcase
   endfunction

   function automatic void flag_result(string what, pwm_level_type want, pwm_level_type got);
      bad_results++;
      if (bad_results <= MAX_REPORTS)
         $display("mismatch, %s: expected pin %b flip %b, got pin %b flip %b", what,
                  want.pin_level, want.phase_switched, got.pin_level, got.phase_switched);
   endfunction

   task automatic send_item(input logic kind, input logic [CW-1:0] period,
                            input logic [DF:0] duty, input logic defer);
      pwm_level_type want;
      if (!sender_steady && burst_left == 0) begin
         @(negedge clock) req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end else begin
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.kind         <= kind;
      req_ch.new_period   <= period;
      req_ch.new_duty     <= duty;
      req_ch.defer_update <= defer;
      do @(posedge clock); while (!req_ch.ready);
      want = advance_pwm(kind, period, duty, defer);
      pending_levels.push_back(want);
      if (want.phase_switched) flips_seen++;
      if (kind == tpwm_pkg::KIND_UPDATE) updates_sent++;
      else ticks_sent++;
      if (burst_left > 0) burst_left--;
   endtask

   task automatic send_tick();
      send_item(tpwm_pkg::KIND_TICK, CW'($urandom), DW'($urandom), 1'($urandom));
   endtask

   task automatic send_update(input logic [CW-1:0] period, input logic [DF:0] duty,
                              input logic defer);
      send_item(tpwm_pkg::KIND_UPDATE, period, duty, defer);
   endtask

   task automatic send_small_update(input logic defer);
      send_update(CW'($urandom_range(0, 24)), random_duty(), defer);
   endtask

   task automatic wait_drain();
      @(negedge clock) req_ch.valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
   endtask

   // first phase switch after reset, with noise updates riding along
   task automatic test_reset_schedule();
      while (tick_count + 1'b1 < phase_len) begin
         if ($urandom_range(0, 31) == 0) send_update(CW'($urandom), DW'($urandom), 1'($urandom));
         else send_tick();
      end
      send_update(24'd8, 17'd32768, 1'b0);
      while (pwm_phase_active) send_tick();
   endtask

   // zero delays, saturation, deferred reload and catch-up of the counter
   task automatic test_directed_cases();
      send_update(24'd0, 17'd0, 1'b0);
      repeat (6) send_tick();
      send_update(24'd3, 17'h1FFFF, 1'b1);
      repeat (11) send_tick();
      send_item(tpwm_pkg::KIND_TICK, 24'hFFFFFF, 17'h1FFFF, 1'b1);
      send_item(tpwm_pkg::KIND_TICK, 24'h000000, 17'h00000, 1'b0);
      send_update(24'hFFFFFF, 17'h1FFFF, 1'b0);
      send_update(24'd6, 17'd1, 1'b0);
      repeat (2) send_tick();
   endtask

   task automatic test_immediate_updates(input int n);
      int sent;
      sent = 0;
      while (sent < n) begin
         send_small_update(1'b0);
         sent++;
         repeat ($urandom_range(0, 10)) begin
            send_tick();
            sent++;
         end
      end
   endtask

   task automatic test_deferred_updates(input int n);
      int sent;
      sent = 0;
      while (sent < n) begin
         send_small_update($urandom_range(0, 3) != 0);
         sent++;
         repeat ($urandom_range(0, 10)) begin
            send_tick();
            sent++;
         end
      end
   endtask

   // wide random updates are always overwritten before the next tick
   task automatic test_mixed_traffic(input int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         sender_steady = (i % 10) >= 7;
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            send_update(CW'($urandom), DW'($urandom), 1'($urandom));
            send_small_update(1'b0);
         end else if (pick < 25) begin
            send_small_update(1'($urandom));
         end else begin
            send_tick();
         end
      end
      sender_steady = 0;
   endtask

   // full-width period product, observed through a short off phase
   task automatic test_wide_period();
      while (!pwm_phase_active) send_tick();
      send_update(24'h800000, 17'd65535, 1'b0);
      while (pwm_phase_active) send_tick();
      while (!pwm_phase_active) send_tick();
      repeat (8) send_tick();
      send_update(24'hFFFFFF, 17'h1FFFF, 1'b1);
      repeat (4) send_tick();
   endtask

   always @(negedge clock) begin
      if (sink_age == 0) begin
         sink_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h8001);
         sink_age     = 128;
      end else begin
         sink_pattern = {sink_pattern[0], sink_pattern[15:1]};
         sink_age--;
      end
      rsp_ch.ready <= sink_pattern[0];
   end

   always @(posedge clock) begin : rsp_check
      pwm_level_type got;
      pwm_level_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.pin_level      = rsp_ch.pin_level;
         got.phase_switched = rsp_ch.phase_switched;
         checked++;
         if (pending_levels.size() == 0) begin
            flag_result("transfer with nothing pending", 'x, got);
         end else begin
            want = pending_levels.pop_front();
            if (got.pin_level !== want.pin_level || got.phase_switched !== want.phase_switched)
               flag_result($sformatf("response %0d", checked), want, got);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", pending_levels.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.kind         = tpwm_pkg::KIND_TICK;
      req_ch.new_period   = '0;
      req_ch.new_duty     = '0;
      req_ch.defer_update = 1'b0;
      rsp_ch.ready        = 1'b0;

      pwm_phase_active = 1'b1;
      shadow_period    = CW'(tpwm_pkg::RESET_PERIOD);
      shadow_duty      = DUTY_ONE >> 1;
      shadow_sticky    = 1'b0;
      load_shadow();
      tick_count       = '0;
      phase_len        = on_len;

      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_reset_schedule();
      test_directed_cases();
      test_immediate_updates(20);
      wait_drain();
      test_deferred_updates(20);
      wait_drain();
      test_mixed_traffic(25);
      test_wide_period();

      wait_drain();
      repeat (6) @(posedge clock);

      $display("covered %0d ticks and %0d period/duty updates with %0d phase flips",
               ticks_sent, updates_sent, flips_seen);
      $display("%0d responses compared, %0d mismatches", checked, bad_results);
      if (bad_results == 0 && pending_levels.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
